[sv/tvd_pkg.sv]
`timescale 1ns / 1ps
// Package for the weighted 1D TV denoiser: word types, fixed-point widths,
// saturation helpers. No dependencies.
package tvd_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int SAMPLE_W    = 24;
  localparam int WEIGHT_W    = 16;
  localparam int PEN_W       = 24;
  localparam int IDX_W       = 6;
  localparam int KNOT_W      = 32;
  localparam int ICPT_W      = 48;
  // divider operand widths: numerators reach 49 bits, denominators 33
  localparam int NUM_W       = 50;
  localparam int DEN_W       = 34;
  localparam logic [PEN_W-1:0] PEN_RESET = 24'd4096;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0]        weight;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]           index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       final_res;
  } out_word_t;

  // one derivative knot with its slope and intercept increments
  typedef struct packed {
    logic signed [KNOT_W-1:0] knot;
    logic signed [KNOT_W-1:0] slope;
    logic signed [ICPT_W-1:0] icpt;
  } knot_t;

  typedef struct packed {
    logic signed [KNOT_W-1:0] low;
    logic signed [KNOT_W-1:0] high;
  } clamp_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) r = v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v[31:23] != {9{v[31]}}) r = v[31] ? 24'sh80_0000 : 24'sh7F_FFFF;
    else r = v[23:0];
    return r;
  endfunction

endpackage

[sv/tvd_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring signed divider, truncating toward zero, 32-bit saturated.
// Depends on tvd_pkg.
module tvd_div import tvd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [31:0]      quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dmag;
  logic             neg;
  logic             nzero;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;
  logic             big_pos;
  logic             big_neg;

  // one quotient bit per cycle
  assign rem_sh = {rem, nq[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes and iteration datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      nq    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg   <= num[NUM_W-1] ^ den[DEN_W-1];
      nzero <= (num == '0);
      rem   <= '0;
    end else if (busy) begin
      rem <= qbit ? DEN_W'(rem_sh - {1'b0, dmag}) : rem_sh[DEN_W-1:0];
      nq  <= {nq[NUM_W-2:0], qbit};
    end
  end

  // sign and saturation; a zero divisor yields all ones and saturates
  assign big_pos = |nq[NUM_W-1:31];
  assign big_neg = (|nq[NUM_W-1:32]) || (nq[31] && (|nq[30:0]));

  always_comb begin
    if (nzero) quot = '0;
    else if (neg) quot = big_neg ? 32'sh8000_0000 : -$signed(nq[31:0]);
    else quot = big_pos ? 32'sh7FFF_FFFF : $signed(nq[31:0]);
  end

endmodule

[sv/weighted_tv_denoise_1d.sv]
`timescale 1ns / 1ps
// Forward step: a left then a right knot scan (read, multiply, compare per visit),
// then two clamp divisions in turn on the shared radix-2 divider; the last sample
// scans left only with one division; the first step adds one more. Back pass: a
// clamp memory read and an emit per word, the emit held while the output stalls.
// One item at a time. Reset is synchronous: counters, pointers, penalty (4096)
// and handshakes clear; memories stay unset. Depends on tvd_pkg and tvd_div.
module weighted_tv_denoise_1d import tvd_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PEN_W-1:0] cfg_data
);

  localparam int AW = $clog2(2 * MAX_LEN);
  localparam int KW = $clog2(MAX_LEN);
  localparam logic [AW-1:0] LEFT0  = AW'(MAX_LEN - 1);
  localparam logic [AW-1:0] RIGHT0 = AW'(MAX_LEN);
  localparam logic [KW-1:0] LAST_K = KW'(MAX_LEN - 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT     = 5'd1;
  localparam logic [4:0] S_INIT_DIV = 5'd2;
  localparam logic [4:0] S_INIT_WR2 = 5'd3;
  localparam logic [4:0] S_PREP     = 5'd4;
  localparam logic [4:0] S_LO_RD    = 5'd5;
  localparam logic [4:0] S_LO_MUL   = 5'd6;
  localparam logic [4:0] S_LO_CMP   = 5'd7;
  localparam logic [4:0] S_HI_RD    = 5'd8;
  localparam logic [4:0] S_HI_MUL   = 5'd9;
  localparam logic [4:0] S_HI_CMP   = 5'd10;
  localparam logic [4:0] S_DIV_LO   = 5'd11;
  localparam logic [4:0] S_DIV_HI   = 5'd12;
  localparam logic [4:0] S_WR1      = 5'd13;
  localparam logic [4:0] S_WR2      = 5'd14;
  localparam logic [4:0] S_FIN_DIV  = 5'd15;
  localparam logic [4:0] S_EMIT_TOP = 5'd16;
  localparam logic [4:0] S_BK_RD    = 5'd17;
  localparam logic [4:0] S_BK_EMIT  = 5'd18;

  logic [4:0]                 state;
  logic [PEN_W-1:0]           penalty;
  logic [KW-1:0]              sample_count;
  logic [AW-1:0]              left_ptr;
  logic [AW-1:0]              right_ptr;
  logic signed [SAMPLE_W-1:0] first_sample;
  logic [WEIGHT_W-1:0]        first_weight;
  logic signed [SAMPLE_W-1:0] y_q;
  logic [WEIGHT_W-1:0]        w_q;
  logic signed [40:0]         wy_q;
  logic signed [40:0]         fwy_q;
  logic                       fin_q;
  logic [KW-1:0]              k_q;
  logic [KW-1:0]              j_q;
  logic [AW-1:0]              lo;
  logic [AW-1:0]              hi;
  logic signed [31:0]         alo;
  logic signed [47:0]         blo;
  logic signed [31:0]         ahi;
  logic signed [47:0]         bhi;
  logic signed [63:0]         prod;
  logic signed [31:0]         lc_q;
  logic signed [31:0]         hc_q;
  logic signed [31:0]         theta_q;

  // knot memory and clamp memory, registered reads
  knot_t  kmem [2*MAX_LEN];
  clamp_t cmem [MAX_LEN];
  knot_t  kmem_rd;
  clamp_t cmem_rd;
  logic          km_we;
  logic [AW-1:0] km_waddr;
  knot_t         km_wdata;
  logic [AW-1:0] km_raddr;
  logic          cm_we;
  logic [KW-1:0] cm_waddr;
  clamp_t        cm_wdata;

  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic                    div_done;
  logic signed [31:0]      div_quot;

  logic                    out_free;
  logic                    out_load;
  logic                    pen_zero;
  logic signed [48:0]      lam49;
  logic                    hi_phase;
  logic signed [47:0]      cur_b;
  logic signed [48:0]      lam_term;
  logic signed [65:0]      cmp_sum;
  logic                    brk;
  logic                    lo_done;
  logic                    hi_done;
  logic signed [31:0]      lc0;
  logic signed [31:0]      hc0;
  logic signed [31:0]      clamped;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign pen_zero  = (penalty == '0);
  assign lam49     = $signed({13'b0, penalty, 12'b0});

  // a new output word is loaded this cycle
  assign out_load = ((state == S_IDLE) && in_valid && in_ready &&
                     (sample_count == '0) && in_word.last) ||
                    (((state == S_EMIT_TOP) || (state == S_BK_EMIT)) && out_free);

  // scan compare: slope*knot + intercept (+ lambda) > 0 ends the scan
  assign hi_phase = (state == S_HI_RD) || (state == S_HI_MUL) || (state == S_HI_CMP);
  assign cur_b    = hi_phase ? bhi : blo;
  assign lam_term = (hi_phase || !fin_q) ? lam49 : 49'sd0;
  assign cmp_sum  = 66'(prod) + 66'(cur_b) + 66'(lam_term);
  assign brk      = !cmp_sum[65] && (cmp_sum != '0);
  assign lo_done  = ((state == S_LO_RD) && (lo > right_ptr)) || ((state == S_LO_CMP) && brk);
  assign hi_done  = ((state == S_HI_RD) && (hi < lo)) || ((state == S_HI_CMP) && brk);

  // first clamp pair from the first sample
  assign lc0 = sat32(33'(first_sample) - 33'(div_quot));
  assign hc0 = sat32(33'(first_sample) + 33'(div_quot));

  // back pass clamp
  always_comb begin
    if (theta_q > cmem_rd.high) clamped = cmem_rd.high;
    else if (theta_q < cmem_rd.low) clamped = cmem_rd.low;
    else clamped = theta_q;
  end

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_INIT: begin
        div_start = 1'b1;
        div_num   = NUM_W'(lam49);
        div_den   = DEN_W'($signed({1'b0, first_weight}));
      end
      S_LO_RD, S_LO_CMP: begin
        div_start = lo_done && fin_q && !pen_zero;
        div_num   = NUM_W'(-(49'(blo)));
        div_den   = DEN_W'(alo);
      end
      S_HI_RD, S_HI_CMP: begin
        div_start = hi_done && !pen_zero;
        div_num   = NUM_W'(-lam49 - 49'(blo));
        div_den   = DEN_W'(alo);
      end
      S_DIV_LO: begin
        div_start = div_done;
        div_num   = NUM_W'(lam49 + 49'(bhi));
        div_den   = -(DEN_W'(ahi));
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // memory write ports
  always_comb begin
    km_we    = 1'b0;
    km_waddr = lo - AW'(1);
    km_wdata = '{knot: lc_q, slope: alo, icpt: sat48(49'(blo) + lam49)};
    cm_we    = 1'b0;
    cm_waddr = k_q;
    cm_wdata = '{low: lc_q, high: hc_q};
    unique case (state)
      S_INIT_DIV: begin
        km_we    = div_done;
        km_waddr = LEFT0;
        km_wdata = '{knot: lc0, slope: 32'($signed({1'b0, first_weight})),
                     icpt: sat48(lam49 - 49'(fwy_q))};
        cm_we    = div_done;
        cm_waddr = '0;
        cm_wdata = '{low: lc0, high: hc0};
      end
      S_INIT_WR2: begin
        km_we    = 1'b1;
        km_waddr = RIGHT0;
        km_wdata = '{knot: hc_q, slope: -(32'($signed({1'b0, first_weight}))),
                     icpt: sat48(lam49 + 49'(fwy_q))};
      end
      S_WR1: begin
        km_we = 1'b1;
        cm_we = 1'b1;
      end
      S_WR2: begin
        km_we    = 1'b1;
        km_waddr = hi + AW'(1);
        km_wdata = '{knot: hc_q, slope: ahi, icpt: sat48(49'(bhi) + lam49)};
      end
      default: begin
        km_we = 1'b0;
      end
    endcase
  end

  assign km_raddr = hi_phase ? hi : lo;

  always_ff @(posedge clk) begin
    if (km_we) kmem[km_waddr] <= km_wdata;
    kmem_rd <= kmem[km_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_waddr] <= cm_wdata;
    cmem_rd <= cmem[j_q];
  end

  tvd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // penalty register
  always_ff @(posedge clk) begin
    if (rst) penalty <= PEN_RESET;
    else if (cfg_valid && cfg_ready) penalty <= cfg_data;
  end

  // control and datapath sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      left_ptr     <= '0;
      right_ptr    <= '0;
      first_sample <= '0;
      first_weight <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            y_q   <= in_word.sample;
            w_q   <= in_word.weight;
            wy_q  <= $signed({1'b0, in_word.weight}) * in_word.sample;
            k_q   <= sample_count;
            fin_q <= in_word.last || (sample_count == LAST_K);
            if (sample_count == '0) begin
              first_sample <= in_word.sample;
              first_weight <= in_word.weight;
              if (in_word.last) begin
                out_valid          <= 1'b1;
                out_word.index     <= '0;
                out_word.value     <= in_word.sample;
                out_word.final_res <= 1'b1;
                sample_count       <= '0;
              end else begin
                sample_count <= KW'(1);
              end
            end else if (sample_count == KW'(1)) begin
              state <= S_INIT;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_INIT: begin
          fwy_q <= $signed({1'b0, first_weight}) * first_sample;
          state <= S_INIT_DIV;
        end
        S_INIT_DIV: begin
          if (div_done) begin
            hc_q  <= hc0;
            state <= S_INIT_WR2;
          end
        end
        S_INIT_WR2: begin
          left_ptr  <= LEFT0;
          right_ptr <= RIGHT0;
          state     <= S_PREP;
        end
        S_PREP: begin
          alo   <= 32'($signed({1'b0, w_q}));
          blo   <= sat48(-(49'(wy_q)) - lam49);
          lo    <= left_ptr;
          state <= S_LO_RD;
        end
        S_LO_RD, S_LO_CMP: begin
          if (lo_done) begin
            if (fin_q) begin
              if (pen_zero) begin
                theta_q <= 32'(y_q);
                state   <= S_EMIT_TOP;
              end else begin
                state <= S_FIN_DIV;
              end
            end else begin
              ahi   <= -(32'($signed({1'b0, w_q})));
              bhi   <= sat48(49'(wy_q) - lam49);
              hi    <= right_ptr;
              state <= S_HI_RD;
            end
          end else if (state == S_LO_RD) begin
            state <= S_LO_MUL;
          end else begin
            alo   <= sat32(33'(alo) + 33'(kmem_rd.slope));
            blo   <= sat48(49'(blo) + 49'(kmem_rd.icpt));
            lo    <= lo + AW'(1);
            state <= S_LO_RD;
          end
        end
        S_LO_MUL: begin
          prod  <= alo * kmem_rd.knot;
          state <= S_LO_CMP;
        end
        S_HI_RD, S_HI_CMP: begin
          if (hi_done) begin
            if (pen_zero) begin
              lc_q  <= 32'(y_q);
              hc_q  <= 32'(y_q);
              state <= S_WR1;
            end else begin
              state <= S_DIV_LO;
            end
          end else if (state == S_HI_RD) begin
            state <= S_HI_MUL;
          end else begin
            ahi   <= sat32(33'(ahi) + 33'(kmem_rd.slope));
            bhi   <= sat48(49'(bhi) + 49'(kmem_rd.icpt));
            hi    <= hi - AW'(1);
            state <= S_HI_RD;
          end
        end
        S_HI_MUL: begin
          prod  <= ahi * kmem_rd.knot;
          state <= S_HI_CMP;
        end
        S_DIV_LO: begin
          if (div_done) begin
            lc_q  <= div_quot;
            state <= S_DIV_HI;
          end
        end
        S_DIV_HI: begin
          if (div_done) begin
            hc_q  <= div_quot;
            state <= S_WR1;
          end
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          left_ptr     <= lo - AW'(1);
          right_ptr    <= hi + AW'(1);
          sample_count <= k_q + KW'(1);
          state        <= S_IDLE;
        end
        S_FIN_DIV: begin
          if (div_done) begin
            theta_q <= div_quot;
            state   <= S_EMIT_TOP;
          end
        end
        S_EMIT_TOP: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_word.index     <= IDX_W'(k_q);
            out_word.value     <= sat24(theta_q);
            out_word.final_res <= 1'b0;
            j_q                <= k_q - KW'(1);
            state              <= S_BK_RD;
          end
        end
        S_BK_RD: begin
          state <= S_BK_EMIT;
        end
        S_BK_EMIT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_word.index     <= IDX_W'(j_q);
            out_word.value     <= sat24(clamped);
            out_word.final_res <= (j_q == '0);
            theta_q            <= clamped;
            if (j_q == '0) begin
              sample_count <= '0;
              left_ptr     <= '0;
              right_ptr    <= '0;
              state        <= S_IDLE;
            end else begin
              j_q   <= j_q - KW'(1);
              state <= S_BK_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // knot window stays ordered once the first step has run
  a_window: assert property (@(posedge clk) disable iff (rst)
    (sample_count >= KW'(2)) |-> (left_ptr < right_ptr))
    else $error("knot window out of order");

  // a quotient only arrives while the sequencer waits for one
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_INIT_DIV || state == S_FIN_DIV ||
                  state == S_DIV_LO || state == S_DIV_HI))
    else $error("divider result with no request pending");

  // left scan never starts outside the stored knots
  a_lo_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_LO_RD) |-> (lo >= left_ptr))
    else $error("left scan below window");

endmodule
